[src/sis_pkg.sv]
// sis_pkg: shared widths, operation codes and status codes of the sparse index set.
// No dependencies; taken in by the channel interfaces and the top level.
package sis_pkg;

   localparam int FUNC_W = 4;
   localparam int ID_W   = 10;
   localparam int LEN_W  = 11;
   localparam int RAND_W = 32;
   localparam int STAT_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FN_FILL      = 4'd0,
      FN_RESTORE   = 4'd1,
      FN_RESIZE    = 4'd2,
      FN_GET       = 4'd3,
      FN_POSITION  = 4'd4,
      FN_EXISTS    = 4'd5,
      FN_ERASE_ID  = 4'd6,
      FN_ERASE_POS = 4'd7,
      FN_DRAW      = 4'd8,
      FN_SET       = 4'd9
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_ID     = 3'd1,
      ST_BAD_SLOT   = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_INACTIVE   = 3'd4,
      ST_EMPTY_DRAW = 3'd5
   } status_type;

endpackage

[src/sis_req_if.sv]
// sis_req_if: request channel of the sparse index set, one beat per operation.
// Depends on sis_pkg for field widths.
interface sis_req_if;
   import sis_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   item_id;
   logic [ID_W-1:0]   slot;
   logic [LEN_W-1:0]  new_length;
   logic [RAND_W-1:0] random_fraction;

   modport source (
      output valid, func, item_id, slot, new_length, random_fraction,
      input  ready
   );

   modport sink (
      input  valid, func, item_id, slot, new_length, random_fraction,
      output ready
   );

endinterface

[src/sis_rsp_if.sv]
// sis_rsp_if: response channel of the sparse index set, one beat per operation.
// Depends on sis_pkg for field widths.
interface sis_rsp_if;
   import sis_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   answer;
   logic              present;
   logic [LEN_W-1:0]  length_now;
   logic [STAT_W-1:0] status;

   modport source (
      output valid, answer, present, length_now, status,
      input  ready
   );

   modport sink (
      input  valid, answer, present, length_now, status,
      output ready
   );

endinterface

[src/sparse_index_set.sv]
// sparse_index_set: id set held as a dense slot-to-id table and a sparse id-to-slot table.
// Depends on sis_pkg, sis_req_if and sis_rsp_if; both tables are single-port-read memories.
// Before S_RESP: none for restore, resize, set, unused codes; S_READ for get, position_of
// and exists; S_DMUL, S_READ for draw; S_ERD1, S_ERD2, S_EWR for erase_pos (S_ERD1 alone
// for the last entry), S_EPOS first for erase_id; S_FILL for fill. One operation at a time,
// set by the read-modify-write sequence on the tables; the next request is taken the cycle
// after the response register loads. Reset: length and capacity go to min(1024, MAX_IDS);
// no clearing pass, tables hold nothing valid until fill or set writes them.
module sparse_index_set #(
   parameter int MAX_IDS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   sis_req_if.sink                    req_bus,
   sis_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [sis_pkg::LEN_W-1:0]  csr_wdata
);
   import sis_pkg::*;

   localparam int CAP_MAX = (MAX_IDS < 2047) ? MAX_IDS : 2047;
   localparam int CAP_RST = (MAX_IDS < 1024) ? MAX_IDS : 1024;
   localparam int AW      = $clog2(CAP_MAX);
   localparam int PROD_W  = LEN_W + RAND_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_READ,
      S_DMUL,
      S_EPOS,
      S_ERD1,
      S_ERD2,
      S_EWR,
      S_RESP
   } state_type;

   state_type         state_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [LEN_W-1:0]  cap_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  cap_in;
   logic [AW-1:0]     fill_cnt_ff;
   logic [AW-1:0]     k_ff;
   logic [AW-1:0]     id_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ID_W-1:0]   res_answer_ff;
   logic              res_present_ff;
   status_type        res_status_ff;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_answer_ff;
   logic              rsp_present_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   status_type        rsp_status_ff;

   logic [AW-1:0]     mas_mem [CAP_MAX];
   logic [AW-1:0]     som_mem [CAP_MAX];
   logic [AW-1:0]     mas_q_ff;
   logic [AW-1:0]     som_q_ff;
   logic              mas_re, mas_we, som_re, som_we;
   logic [AW-1:0]     mas_raddr, mas_waddr, mas_wdata;
   logic [AW-1:0]     som_raddr, som_waddr, som_wdata;

   logic              req_take;
   logic              rsp_free;
   logic              id_ok;
   logic              slot_ok;
   logic [LEN_W-1:0]  last_len;
   logic [AW-1:0]     last_addr;
   logic [LEN_W-1:0]  draw_pos;

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign req_take           = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free           = !rsp_valid_ff || rsp_bus.ready;
   assign id_ok              = LEN_W'(req_bus.item_id) < cap_ff;
   assign slot_ok            = LEN_W'(req_bus.slot) < len_ff;
   assign last_len           = len_ff - LEN_W'(1);
   assign last_addr          = AW'(last_len);
   assign draw_pos           = prod_ff[PROD_W-1 -: LEN_W];

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.answer     = rsp_answer_ff;
   assign rsp_bus.present    = rsp_present_ff;
   assign rsp_bus.length_now = rsp_length_ff;
   assign rsp_bus.status     = rsp_status_ff;

   always_comb begin
      if (csr_wdata == '0) begin
         cap_in = LEN_W'(1);
      end else if (32'(csr_wdata) > CAP_MAX) begin
         cap_in = LEN_W'(CAP_MAX);
      end else begin
         cap_in = csr_wdata;
      end
   end

   always_comb begin
      mas_re    = 1'b0;
      mas_raddr = '0;
      mas_we    = 1'b0;
      mas_waddr = '0;
      mas_wdata = '0;
      som_re    = 1'b0;
      som_raddr = '0;
      som_we    = 1'b0;
      som_waddr = '0;
      som_wdata = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_bus.func)
                  FN_GET, FN_ERASE_POS: begin
                     mas_re    = slot_ok;
                     mas_raddr = AW'(req_bus.slot);
                  end
                  FN_POSITION, FN_EXISTS, FN_ERASE_ID: begin
                     som_re    = id_ok;
                     som_raddr = AW'(req_bus.item_id);
                  end
                  FN_SET: begin
                     mas_we    = id_ok;
                     mas_waddr = AW'(req_bus.item_id);
                     mas_wdata = AW'(req_bus.item_id);
                     som_we    = id_ok;
                     som_waddr = AW'(req_bus.item_id);
                     som_wdata = AW'(req_bus.item_id);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILL: begin
            mas_we    = 1'b1;
            mas_waddr = fill_cnt_ff;
            mas_wdata = fill_cnt_ff;
            som_we    = 1'b1;
            som_waddr = fill_cnt_ff;
            som_wdata = fill_cnt_ff;
         end
         S_DMUL: begin
            mas_re    = 1'b1;
            mas_raddr = AW'(draw_pos);
         end
         S_EPOS: begin
            mas_re    = LEN_W'(som_q_ff) < len_ff;
            mas_raddr = som_q_ff;
         end
         S_ERD1: begin
            mas_re    = 1'b1;
            mas_raddr = last_addr;
         end
         S_ERD2: begin
            mas_we    = 1'b1;
            mas_waddr = k_ff;
            mas_wdata = mas_q_ff;
            som_we    = 1'b1;
            som_waddr = mas_q_ff;
            som_wdata = k_ff;
         end
         S_EWR: begin
            mas_we    = 1'b1;
            mas_waddr = last_addr;
            mas_wdata = id_ff;
            som_we    = 1'b1;
            som_waddr = id_ff;
            som_wdata = last_addr;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mas_we) begin
         mas_mem[mas_waddr] <= mas_wdata;
      end
      if (mas_re) begin
         mas_q_ff <= mas_mem[mas_raddr];
      end
      if (som_we) begin
         som_mem[som_waddr] <= som_wdata;
      end
      if (som_re) begin
         som_q_ff <= som_mem[som_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= LEN_W'(CAP_RST);
         len_ff       <= LEN_W'(CAP_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= cap_in;
            len_ff <= cap_in;
         end
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  func_ff        <= req_bus.func;
                  res_answer_ff  <= '0;
                  res_present_ff <= 1'b0;
                  res_status_ff  <= ST_OK;
                  k_ff           <= AW'(req_bus.slot);
                  fill_cnt_ff    <= '0;
                  prod_ff        <= PROD_W'(len_ff) * PROD_W'(req_bus.random_fraction);
                  state_ff       <= S_RESP;
                  case (req_bus.func)
                     FN_FILL: begin
                        state_ff <= S_FILL;
                     end
                     FN_RESTORE: begin
                        len_ff <= cap_ff;
                     end
                     FN_RESIZE: begin
                        if (req_bus.new_length > cap_ff) begin
                           res_status_ff <= ST_BAD_LENGTH;
                        end else begin
                           len_ff <= req_bus.new_length;
                        end
                     end
                     FN_GET: begin
                        if (slot_ok) begin
                           state_ff <= S_READ;
                        end else begin
                           res_status_ff <= ST_BAD_SLOT;
                        end
                     end
                     FN_POSITION, FN_EXISTS: begin
                        if (id_ok) begin
                           state_ff <= S_READ;
                        end else begin
                           res_status_ff <= ST_BAD_ID;
                        end
                     end
                     FN_ERASE_ID: begin
                        if (id_ok) begin
                           state_ff <= S_EPOS;
                        end else begin
                           res_status_ff <= ST_BAD_ID;
                        end
                     end
                     FN_ERASE_POS: begin
                        if (slot_ok) begin
                           state_ff <= S_ERD1;
                        end else begin
                           res_status_ff <= ST_BAD_SLOT;
                        end
                     end
                     FN_DRAW: begin
                        if (len_ff != '0) begin
                           state_ff <= S_DMUL;
                        end else begin
                           res_status_ff <= ST_EMPTY_DRAW;
                        end
                     end
                     FN_SET: begin
                        if (!id_ok) begin
                           res_status_ff <= ST_BAD_ID;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_FILL: begin
               fill_cnt_ff <= fill_cnt_ff + AW'(1);
               if (LEN_W'(fill_cnt_ff) == cap_ff - LEN_W'(1)) begin
                  len_ff   <= cap_ff;
                  state_ff <= S_RESP;
               end
            end
            S_DMUL: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               case (func_ff)
                  FN_POSITION: begin
                     res_answer_ff <= ID_W'(som_q_ff);
                  end
                  FN_EXISTS: begin
                     res_present_ff <= LEN_W'(som_q_ff) < len_ff;
                  end
                  default: begin
                     res_answer_ff <= ID_W'(mas_q_ff);
                  end
               endcase
               state_ff <= S_RESP;
            end
            S_EPOS: begin
               if (LEN_W'(som_q_ff) < len_ff) begin
                  k_ff     <= som_q_ff;
                  state_ff <= S_ERD1;
               end else begin
                  res_status_ff <= ST_INACTIVE;
                  state_ff      <= S_RESP;
               end
            end
            S_ERD1: begin
               id_ff <= mas_q_ff;
               if (k_ff == last_addr) begin
                  len_ff   <= last_len;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_ERD2;
               end
            end
            S_ERD2: begin
               state_ff <= S_EWR;
            end
            S_EWR: begin
               len_ff   <= last_len;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_answer_ff  <= res_answer_ff;
                  rsp_present_ff <= res_present_ff;
                  rsp_length_ff  <= len_ff;
                  rsp_status_ff  <= res_status_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_len_within_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= cap_ff)
      else $error("active length above capacity");

   a_cap_in_range: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) && (32'(cap_ff) <= CAP_MAX))
      else $error("capacity out of range");

   a_draw_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DMUL) |-> (draw_pos < len_ff))
      else $error("draw position not below active length");

   a_fill_below_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (LEN_W'(fill_cnt_ff) < cap_ff))
      else $error("fill sweep past capacity");

   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EWR) |=> (len_ff == $past(len_ff) - LEN_W'(1)))
      else $error("erase did not shrink length by one");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for sparse_index_set, directed and random operation beats.
// Depends on sis_pkg, sis_req_if, sis_rsp_if and the sparse_index_set top level.
// Predicts every response from a local copy of both tables, length and capacity.
module tb_top;
   import sis_pkg::*;

   localparam int MAX_IDS        = 1024;
   localparam int IDLE_PCT       = 37;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int PHASE_OPS      = 50;
   localparam int PHASES         = 8;

   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd10;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   item_id;
      logic [ID_W-1:0]   slot;
      logic [LEN_W-1:0]  new_length;
      logic [RAND_W-1:0] random_fraction;
   } op_beat_t;

   typedef struct packed {
      logic [ID_W-1:0]   answer;
      logic              present;
      logic [LEN_W-1:0]  length_now;
      logic [STAT_W-1:0] status;
   } rsp_beat_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [LEN_W-1:0] csr_wdata;

   sis_req_if req_bus ();
   sis_rsp_if rsp_bus ();

   sparse_index_set #(
      .MAX_IDS (MAX_IDS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [ID_W-1:0]  slot_to_id [0:MAX_IDS-1];
   logic [ID_W-1:0]  id_to_slot [0:MAX_IDS-1];
   bit               slot_written [0:MAX_IDS-1];
   bit               id_written [0:MAX_IDS-1];
   logic [LEN_W-1:0] set_length   = LEN_W'(MAX_IDS);
   logic [LEN_W-1:0] set_capacity = LEN_W'(MAX_IDS);

   op_beat_t  pending_ops [$];
   rsp_beat_t expected_rsp [$];
   rsp_beat_t predicted;
   rsp_beat_t oldest_rsp;

   bit calm = 1'b0;
   int mismatches = 0;
   int ops_sent = 0;
   int rsp_checked = 0;
   int faults_predicted = 0;
   int cap_settings = 0;
   int quiet_cycles = 0;
   bit req_accept;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void drop_slot(input logic [ID_W-1:0] k);
      logic [ID_W-1:0] gone;
      logic [ID_W-1:0] moved;
      logic [ID_W-1:0] last;
      gone = slot_to_id[k];
      set_length = set_length - 1'b1;
      last = set_length[ID_W-1:0];
      if (k != last) begin
         moved = slot_to_id[last];
         slot_to_id[k] = moved;
         slot_to_id[last] = gone;
         id_to_slot[moved] = k;
         id_to_slot[gone] = last;
         id_written[moved] = 1'b1;
         id_written[gone] = 1'b1;
      end
   endfunction

   function automatic rsp_beat_t apply_op(input op_beat_t op);
      rsp_beat_t rsp;
      logic [63:0] prod;
      int i;
      rsp = '0;
      case (op.func)
         FN_FILL: begin
            for (i = 0; i < set_capacity; i++) begin
               slot_to_id[i] = ID_W'(i);
               id_to_slot[i] = ID_W'(i);
               slot_written[i] = 1'b1;
               id_written[i] = 1'b1;
            end
            set_length = set_capacity;
         end
         FN_RESTORE: begin
            set_length = set_capacity;
         end
         FN_RESIZE: begin
            if (op.new_length > set_capacity) rsp.status = ST_BAD_LENGTH;
            else set_length = op.new_length;
         end
         FN_GET: begin
            if (op.slot >= set_length) rsp.status = ST_BAD_SLOT;
            else rsp.answer = slot_to_id[op.slot];
         end
         FN_POSITION: begin
            if (op.item_id >= set_capacity) rsp.status = ST_BAD_ID;
            else rsp.answer = id_to_slot[op.item_id];
         end
         FN_EXISTS: begin
            if (op.item_id >= set_capacity) rsp.status = ST_BAD_ID;
            else rsp.present = (id_to_slot[op.item_id] < set_length);
         end
         FN_ERASE_ID: begin
            if (op.item_id >= set_capacity) rsp.status = ST_BAD_ID;
            else if (id_to_slot[op.item_id] >= set_length) rsp.status = ST_INACTIVE;
            else drop_slot(id_to_slot[op.item_id]);
         end
         FN_ERASE_POS: begin
            if (op.slot >= set_length) rsp.status = ST_BAD_SLOT;
            else drop_slot(op.slot);
         end
         FN_DRAW: begin
            if (set_length == 0) begin
               rsp.status = ST_EMPTY_DRAW;
            end else begin
               prod = 64'(set_length) * 64'(op.random_fraction);
               rsp.answer = slot_to_id[prod[41:32]];
            end
         end
         FN_SET: begin
            if (op.item_id >= set_capacity) begin
               rsp.status = ST_BAD_ID;
            end else begin
               slot_to_id[op.item_id] = op.item_id;
               id_to_slot[op.item_id] = op.item_id;
               slot_written[op.item_id] = 1'b1;
               id_written[op.item_id] = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.length_now = set_length;
      return rsp;
   endfunction

   // true when the beat touches only table entries that fill, set or an erase wrote
   function automatic bit reads_defined(input op_beat_t op);
      logic [63:0] prod;
      logic [ID_W-1:0] last;
      logic [ID_W-1:0] pos;
      last = ID_W'(set_length - 1'b1);
      case (op.func)
         FN_GET: begin
            if (op.slot < set_length) return slot_written[op.slot];
         end
         FN_POSITION, FN_EXISTS: begin
            if (op.item_id < set_capacity) return id_written[op.item_id];
         end
         FN_ERASE_ID: begin
            if (op.item_id < set_capacity) begin
               if (!id_written[op.item_id]) return 1'b0;
               pos = id_to_slot[op.item_id];
               if (pos < set_length) return slot_written[pos] && slot_written[last];
            end
         end
         FN_ERASE_POS: begin
            if (op.slot < set_length) return slot_written[op.slot] && slot_written[last];
         end
         FN_DRAW: begin
            if (set_length != 0) begin
               prod = 64'(set_length) * 64'(op.random_fraction);
               return slot_written[prod[41:32]];
            end
         end
         default: begin
         end
      endcase
      return 1'b1;
   endfunction

   function automatic op_beat_t make_op(input logic [FUNC_W-1:0] func,
                                        input logic [ID_W-1:0] item_id,
                                        input logic [ID_W-1:0] slot,
                                        input logic [LEN_W-1:0] new_length,
                                        input logic [RAND_W-1:0] random_fraction);
      op_beat_t op;
      op.func = func;
      op.item_id = item_id;
      op.slot = slot;
      op.new_length = new_length;
      op.random_fraction = random_fraction;
      return op;
   endfunction

   function automatic op_beat_t random_op();
      op_beat_t op;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) op.func = FN_FILL;
      else if (pick < 8) op.func = FN_RESTORE;
      else if (pick < 16) op.func = FN_RESIZE;
      else if (pick < 28) op.func = FN_GET;
      else if (pick < 38) op.func = FN_POSITION;
      else if (pick < 48) op.func = FN_EXISTS;
      else if (pick < 60) op.func = FN_ERASE_ID;
      else if (pick < 72) op.func = FN_ERASE_POS;
      else if (pick < 86) op.func = FN_DRAW;
      else if (pick < 96) op.func = FN_SET;
      else op.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      if ($urandom_range(0, 4) == 0) op.item_id = ID_W'($urandom);
      else op.item_id = ID_W'($urandom_range(0, set_capacity - 1));
      if (set_length == 0 || $urandom_range(0, 4) == 0) op.slot = ID_W'($urandom);
      else op.slot = ID_W'($urandom_range(0, set_length - 1));
      if ($urandom_range(0, 4) == 0) op.new_length = LEN_W'($urandom);
      else op.new_length = LEN_W'($urandom_range(0, set_capacity));
      pick = $urandom_range(0, 9);
      if (pick == 0) op.random_fraction = '0;
      else if (pick == 1) op.random_fraction = '1;
      else op.random_fraction = $urandom;
      return op;
   endfunction

   // hold until the last beat is taken; with drain, until every response is back
   task automatic wait_turn(input bit drain);
      while (pending_ops.size() != 0) @(negedge clock);
      if (drain) begin
         while (expected_rsp.size() != 0) @(negedge clock);
      end
   endtask

   task automatic queue_op(input op_beat_t op);
      if (!reads_defined(op)) op.func = FN_FILL;
      pending_ops.push_back(op);
      ops_sent++;
   endtask

   task automatic write_capacity(input logic [LEN_W-1:0] value);
      wait_turn(1'b1);
      repeat (8) @(negedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (value == 0) set_capacity = 1;
      else if (value > MAX_IDS) set_capacity = LEN_W'(MAX_IDS);
      else set_capacity = value;
      set_length = set_capacity;
      cap_settings++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.func <= '0;
         req_bus.item_id <= '0;
         req_bus.slot <= '0;
         req_bus.new_length <= '0;
         req_bus.random_fraction <= '0;
      end else begin
         req_accept = req_bus.valid && req_bus.ready;
         if (req_accept) begin
            predicted = apply_op(pending_ops.pop_front());
            if (predicted.status != ST_OK) faults_predicted++;
            expected_rsp.push_back(predicted);
         end
         if (req_bus.valid && !req_accept) begin
         end else if (pending_ops.size() != 0 &&
                      (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_bus.valid <= 1'b1;
            req_bus.func <= pending_ops[0].func;
            req_bus.item_id <= pending_ops[0].item_id;
            req_bus.slot <= pending_ops[0].slot;
            req_bus.new_length <= pending_ops[0].new_length;
            req_bus.random_fraction <= pending_ops[0].random_fraction;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with no expected response");
               mismatches++;
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               rsp_checked++;
               if (rsp_bus.answer !== oldest_rsp.answer) begin
                  $error("answer: expected %0d, actual %0d", oldest_rsp.answer, rsp_bus.answer);
                  mismatches++;
               end
               if (rsp_bus.present !== oldest_rsp.present) begin
                  $error("present: expected %0d, actual %0d", oldest_rsp.present,
                         rsp_bus.present);
                  mismatches++;
               end
               if (rsp_bus.length_now !== oldest_rsp.length_now) begin
                  $error("length_now: expected %0d, actual %0d", oldest_rsp.length_now,
                         rsp_bus.length_now);
                  mismatches++;
               end
               if (rsp_bus.status !== oldest_rsp.status) begin
                  $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp_bus.status);
                  mismatches++;
               end
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sparse_index_set verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int cap_plan [PHASES];
      int phase;
      int n;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      cap_plan = '{2047, 1, 2, 0, 3, 1025, 5, 64};
      cap_plan[4] = $urandom_range(3, 40);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      wait_turn(0); queue_op(make_op(FN_RESTORE, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_RESIZE, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_DRAW, 0, 0, 0, 32'h8000_0000));
      wait_turn(0); queue_op(make_op(FN_GET, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_RESIZE, 0, 0, 1025, 0));
      wait_turn(0); queue_op(make_op(FN_RESIZE, 0, 0, 2047, 0));
      wait_turn(0); queue_op(make_op(FN_FILL, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_GET, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_GET, 0, 1023, 0, 0));
      wait_turn(0); queue_op(make_op(FN_POSITION, 1023, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_EXISTS, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_ERASE_ID, 1023, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_ERASE_ID, 1023, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_EXISTS, 1023, 0, 0, 0));
      wait_turn(1); queue_op(make_op(FN_ERASE_POS, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_GET, 0, 1022, 0, 0));
      wait_turn(0); queue_op(make_op(FN_DRAW, 0, 0, 0, 32'h0000_0000));
      wait_turn(0); queue_op(make_op(FN_DRAW, 0, 0, 0, 32'hFFFF_FFFF));
      wait_turn(0); queue_op(make_op(FN_SET, 1023, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_RESIZE, 0, 0, 1024, 0));
      wait_turn(0); queue_op(make_op(FN_SPARE_HI, 0, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_SPARE_LO, 1023, 1023, 2047, 32'hFFFF_FFFF));
      write_capacity(0);
      wait_turn(0); queue_op(make_op(FN_POSITION, 1, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_SET, 1023, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_ERASE_POS, 0, 1023, 0, 0));
      wait_turn(0); queue_op(make_op(FN_ERASE_ID, 1, 0, 0, 0));
      wait_turn(0); queue_op(make_op(FN_DRAW, 0, 0, 0, 32'hFFFF_FFFF));
      wait_turn(0); queue_op(make_op(FN_EXISTS, 0, 0, 0, 0));

      for (phase = 0; phase < PHASES; phase++) begin
         write_capacity(LEN_W'(cap_plan[phase]));
         calm = (phase == 5);
         wait_turn(0);
         queue_op(make_op(FN_FILL, ID_W'($urandom), ID_W'($urandom), LEN_W'($urandom),
                          $urandom));
         for (n = 1; n < PHASE_OPS; n++) begin
            wait_turn($urandom_range(0, 24) == 0);
            queue_op(random_op());
         end
      end
      calm = 1'b0;

      wait_turn(1'b1);
      repeat (20) @(negedge clock);
      $display("covered %0d operation beats over %0d capacity settings, including extremes",
               ops_sent, cap_settings);
      $display("compared %0d responses, %0d of them with a fault status",
               rsp_checked, faults_predicted);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("sparse_index_set verification clean");
      end else begin
         $display("sparse_index_set verification failed");
      end
      $finish;
   end

endmodule
